// ===== rtl/core/rbt_pkg.sv =====
`timescale 1ns / 1ps
package rbt_pkg;
  localparam int NUM_IDS_DEF   = 256;
  localparam int NUM_RANKS_DEF = 16;
  localparam int MAX_K_DEF     = 64;
  localparam int ID_W   = 8;
  localparam int RANK_W = 4;
  localparam int K_W    = 7;
  localparam logic [1:0] OP_SET    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_BOTTOM = 2'd2;
  localparam logic [1:0] OP_TOP    = 2'd3;
endpackage

// ===== rtl/core/rank_bucket_table.sv =====
`timescale 1ns / 1ps
// Bucket queue of ids ranked into NUM_RANKS buckets. Set rank and remove read
// the id's rank and position from the id memory, read the last entry of the
// old bucket from the entry memory and move it into the freed slot, then
// append the id to its new bucket (set) or mark it unranked (remove). A query
// checks the buckets in turn, does a bucket check, an entry memory read and an
// output load per emitted id, shows the final word when the scan runs out of
// buckets, and gives an empty answer when it finds no id. After reset a
// clearing pass marks every id unranked before the first item is taken. Ids
// at or above NUM_IDS in set and remove, and ranks at or above NUM_RANKS in
// set, are ignored; count_wanted above MAX_K is limited to MAX_K.
module rank_bucket_table
  import rbt_pkg::*;
#(
  parameter int NUM_IDS   = NUM_IDS_DEF,
  parameter int NUM_RANKS = NUM_RANKS_DEF,
  parameter int MAX_K     = MAX_K_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_op,
  input  logic [ID_W-1:0]   in_id,
  input  logic [RANK_W-1:0] in_new_rank,
  input  logic [K_W-1:0]    in_count_wanted,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ID_W-1:0]   out_result_id,
  output logic              out_found,
  output logic              out_last
);
  localparam int IW = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
  localparam int RW = (NUM_RANKS > 1) ? $clog2(NUM_RANKS) : 1;
  localparam int FW = $clog2(NUM_IDS + 1);
  localparam int CW = $clog2(MAX_K + 1);
  localparam int EW = RW + IW;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RDID, S_MOVE, S_APPEND,
    S_QSCAN, S_QREAD, S_QEMIT, S_QEMPTY
  } state_t;

  // id memory: {ranked, rank, position}
  typedef struct packed {
    logic          ranked;
    logic [RW-1:0] rank;
    logic [IW-1:0] pos;
  } idrec_t;

  idrec_t          id_mem [NUM_IDS];
  logic [ID_W-1:0] ent_mem [NUM_RANKS*NUM_IDS];
  logic [FW-1:0]   fill_r [NUM_RANKS];

  state_t          state_r;
  logic [IW-1:0]   clr_r;
  logic [1:0]      op_r;
  logic [IW-1:0]   id_r;
  logic [RW-1:0]   nrank_r;
  logic [CW-1:0]   k_r, n_r;
  idrec_t          rec_r;
  logic [RW-1:0]   qr_r;
  logic [IW-1:0]   qi_r;
  logic [ID_W-1:0] ent_q;
  idrec_t          id_q;
  logic [FW-1:0]   rdfill_r;
  logic            idok;
  logic [CW-1:0]   k_lim;

  logic            id_we, ent_we, ent_re;
  logic [IW-1:0]   id_wa, id_ra;
  idrec_t          id_wd;
  logic [EW-1:0]   ent_wa, ent_ra;
  logic [ID_W-1:0] ent_wd;

  assign in_ready = (state_r == S_IDLE) && !out_valid;
  assign idok = ({{(32-ID_W){1'b0}}, in_id} < 32'(NUM_IDS));
  assign k_lim = ({{(32-K_W){1'b0}}, in_count_wanted} > 32'(MAX_K)) ?
                 CW'(MAX_K) : CW'(in_count_wanted);

  always_ff @(posedge clk) begin
    if (id_we) id_mem[id_wa] <= id_wd;
    id_q <= id_mem[id_ra];
  end

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
    if (ent_re) ent_q <= ent_mem[ent_ra];
  end

  always_comb begin
    id_we  = 1'b0;
    id_wa  = id_r;
    id_wd  = '0;
    id_ra  = id_r;
    ent_we = 1'b0;
    ent_wa = {rec_r.rank, rec_r.pos};
    ent_wd = ent_q;
    ent_re = 1'b0;
    ent_ra = {qr_r, qi_r};
    case (state_r)
      S_CLR: begin
        id_we = 1'b1;
        id_wa = clr_r;
      end
      S_IDLE: id_ra = IW'(in_id);
      S_RDID: begin
        ent_re = 1'b1;
        ent_ra = {id_q.rank, IW'(fill_r[id_q.rank] - FW'(1))};
      end
      S_MOVE: begin
        // ent_q holds the moved tail id
        if (rec_r.pos != IW'(rdfill_r - FW'(1))) begin
          ent_we = 1'b1;
          id_we  = 1'b1;
          id_wa  = IW'(ent_q);
          id_wd  = '{ranked: 1'b1, rank: rec_r.rank, pos: rec_r.pos};
        end
      end
      S_APPEND: begin
        id_we = 1'b1;
        if (op_r == OP_SET) begin
          if (fill_r[nrank_r] != FW'(NUM_IDS)) begin
            id_wd  = '{ranked: 1'b1, rank: nrank_r, pos: IW'(fill_r[nrank_r])};
            ent_we = 1'b1;
            ent_wa = {nrank_r, IW'(fill_r[nrank_r])};
            ent_wd = ID_W'(id_r);
          end
        end
      end
      S_QREAD: ent_re = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_r     <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_RANKS; i++) fill_r[i] <= '0;
    end else begin
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + IW'(1);
          if (clr_r == IW'(NUM_IDS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (out_valid && out_ready) out_valid <= 1'b0;
          if (in_valid && in_ready) begin
            op_r    <= in_op;
            id_r    <= IW'(in_id);
            nrank_r <= RW'(in_new_rank);
            k_r     <= k_lim;
            n_r     <= '0;
            qi_r    <= '0;
            qr_r    <= (in_op == OP_TOP) ? RW'(NUM_RANKS - 1) : '0;
            case (in_op)
              OP_SET: begin
                if (idok && ({{(32-RANK_W){1'b0}}, in_new_rank} < 32'(NUM_RANKS)))
                  state_r <= S_RDID;
              end
              OP_REMOVE: if (idok) state_r <= S_RDID;
              default: state_r <= (k_lim == '0) ? S_QEMPTY : S_QSCAN;
            endcase
          end
        end
        S_RDID: begin
          rec_r    <= id_q;
          rdfill_r <= fill_r[id_q.rank];
          if (id_q.ranked) begin
            state_r <= S_MOVE;
            fill_r[id_q.rank] <= fill_r[id_q.rank] - FW'(1);
          end else begin
            state_r <= (op_r == OP_SET) ? S_APPEND : S_IDLE;
          end
        end
        S_MOVE: state_r <= S_APPEND;
        S_APPEND: begin
          if (op_r == OP_SET && fill_r[nrank_r] != FW'(NUM_IDS))
            fill_r[nrank_r] <= fill_r[nrank_r] + FW'(1);
          state_r <= S_IDLE;
        end
        S_QSCAN: begin
          if (FW'(qi_r) < fill_r[qr_r]) begin
            // show the held word, it is not the last
            if (n_r != '0) out_valid <= 1'b1;
            state_r <= S_QREAD;
          end else if ((op_r == OP_BOTTOM && qr_r == RW'(NUM_RANKS - 1)) ||
                       (op_r == OP_TOP && qr_r == '0)) begin
            if (n_r == '0) state_r <= S_QEMPTY;
            else begin
              out_last <= 1'b1;
              state_r  <= S_QEMIT;
            end
          end else begin
            qi_r <= '0;
            qr_r <= (op_r == OP_TOP) ? qr_r - RW'(1) : qr_r + RW'(1);
          end
        end
        S_QREAD: begin
          // hold the previous word until taken, then show the next
          if (!out_valid || out_ready) begin
            state_r   <= S_QEMIT;
            out_last  <= 1'b0;
            out_valid <= 1'b0;
          end else state_r <= S_QREAD;
        end
        S_QEMIT: begin
          if (!out_valid || out_ready) begin
            if (out_last && n_r != '0 && FW'(qi_r) >= fill_r[qr_r]) begin
              out_valid <= 1'b1;
              state_r   <= S_IDLE;
            end else begin
              out_result_id <= ent_q;
              out_found     <= 1'b1;
              n_r           <= n_r + CW'(1);
              qi_r          <= qi_r + IW'(1);
              if (n_r + CW'(1) == k_r) begin
                out_last  <= 1'b1;
                out_valid <= 1'b1;
                state_r   <= S_IDLE;
              end else begin
                state_r <= S_QSCAN;
              end
            end
          end
        end
        S_QEMPTY: begin
          if (!out_valid) begin
            out_result_id <= '0;
            out_found     <= 1'b0;
            out_last      <= 1'b1;
            out_valid     <= 1'b1;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
